// ===== rtl/bafs_pkg.sv =====
// bafs_pkg: shared types, status and register codes for the bit field store
// depends on nothing; used by every module of the block
`default_nettype none

package bafs_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BEFORE  = 2'd1;
  localparam logic [1:0] ST_ESCAPE  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  localparam logic [1:0] CFG_STORAGE_BITS  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_ENABLE = 2'd1;
  localparam logic [1:0] CFG_WINDOW_BASE   = 2'd2;
  localparam logic [1:0] CFG_WINDOW_BITS   = 2'd3;

  localparam logic [12:0] STORAGE_BITS_RESET = 13'd4096;

  typedef struct packed {
    logic        func;
    logic [12:0] bit_offset;
    logic [6:0]  bit_count;
    logic [63:0] store_data;
  } req_t;

  typedef struct packed {
    logic [63:0] load_data;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    req_t       req;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [12:0] storage_bits;
    logic        window_enable;
    logic [12:0] window_base;
    logic [12:0] window_bits;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bafs_front.sv =====
// bafs_front: takes requests and runs the window and storage bound checks
// depends on bafs_pkg
`default_nettype none

module bafs_front #(
  parameter int STORAGE_WORDS = 64
) (
  input  wire logic           start,
  input  wire bafs_pkg::req_t req,
  input  wire bafs_pkg::cfg_t cfg,
  input  wire logic           full,
  input  wire logic           clearing,
  output logic                busy,
  output logic                push,
  output bafs_pkg::cmd_t      cmd
);

  localparam int CAP = STORAGE_WORDS * 64;
  localparam int CAP_BITS = $clog2(CAP + 1);
  localparam int BW = (CAP_BITS > 13) ? CAP_BITS : 13;

  logic [12:0]   rel;
  logic [12:0]   count_13;
  logic [BW-1:0] cap_w;
  logic [BW-1:0] bound;
  logic [BW-1:0] off_w;
  logic [BW-1:0] count_w;
  logic [BW-1:0] room;
  logic [1:0]    status;

  assign busy = full || clearing;
  assign push = start && !busy;

  always_comb begin
    count_13 = {6'b0, req.bit_count};
    rel      = req.bit_offset - cfg.window_base;
    cap_w    = BW'(CAP);
    bound    = (BW'(cfg.storage_bits) < cap_w) ? BW'(cfg.storage_bits) : cap_w;
    off_w    = BW'(req.bit_offset);
    count_w  = BW'(req.bit_count);
    room     = bound - off_w;
    status   = bafs_pkg::ST_OK;
    if (cfg.window_enable) begin
      if (req.bit_offset < cfg.window_base) begin
        status = bafs_pkg::ST_BEFORE;
      end else if (rel > cfg.window_bits || count_13 > cfg.window_bits - rel) begin
        status = bafs_pkg::ST_ESCAPE;
      end
    end
    if (status == bafs_pkg::ST_OK) begin
      if (req.bit_count > 7'(bafs_pkg::MAX_FIELD_BITS) || off_w > bound ||
          count_w > room) begin
        status = bafs_pkg::ST_OUTSIDE;
      end
    end
    cmd.req    = req;
    cmd.status = status;
  end

endmodule

`default_nettype wire

// ===== rtl/bafs_queue.sv =====
// bafs_queue: short request queue between the check front and the access back
// depends on bafs_pkg
`default_nettype none

module bafs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bafs_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output bafs_pkg::cmd_t      head
);

  localparam int PW = (bafs_pkg::QUEUE_DEPTH > 1) ? $clog2(bafs_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(bafs_pkg::QUEUE_DEPTH + 1);

  bafs_pkg::cmd_t entries [bafs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(bafs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(bafs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(bafs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bafs_back.sv =====
// bafs_back: two-bank word memory, field read-modify-write and result register
// depends on bafs_pkg; even words in one bank, odd words in the other
`default_nettype none

module bafs_back #(
  parameter int STORAGE_WORDS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire bafs_pkg::cmd_t head,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output bafs_pkg::rsp_t      rsp
);

  localparam int BANK_DEPTH = (STORAGE_WORDS + 1) / 2;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  function automatic logic [63:0] field_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

  state_t state;

  logic [63:0] even_mem [BANK_DEPTH];
  logic [63:0] odd_mem  [BANK_DEPTH];
  logic [63:0] rd_even;
  logic [63:0] rd_odd;

  logic [AW-1:0] clr_idx;

  logic [6:0]    w;
  logic [7:0]    w_plus1;
  logic [5:0]    sh;
  logic [63:0]   mask;
  logic [AW-1:0] even_ra;
  logic [AW-1:0] odd_ra;

  logic          func_q;
  logic [1:0]    status_q;
  logic [5:0]    sh_q;
  logic [63:0]   mask_q;
  logic [127:0]  m128_q;
  logic [127:0]  d128_q;
  logic          lo_odd_q;
  logic [AW-1:0] even_addr_q;
  logic [AW-1:0] odd_addr_q;

  logic [63:0]   lo;
  logic [63:0]   hi;
  logic [127:0]  cur;
  logic [127:0]  shifted;
  logic [127:0]  merged;
  logic [63:0]   value;
  logic          we_lo;
  logic          we_hi;

  logic          even_we;
  logic [AW-1:0] even_wa;
  logic [63:0]   even_wd;
  logic          odd_we;
  logic [AW-1:0] odd_wa;
  logic [63:0]   odd_wd;

  assign pop      = (state == S_IDLE) && !empty;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    w       = head.req.bit_offset[12:6];
    w_plus1 = {1'b0, w} + 8'd1;
    sh      = head.req.bit_offset[5:0];
    mask    = (head.status == bafs_pkg::ST_OK) ? field_mask(head.req.bit_count) : '0;
    even_ra = AW'(w_plus1[7:1]);
    odd_ra  = AW'(w[6:1]);
  end

  always_comb begin
    lo      = lo_odd_q ? rd_odd : rd_even;
    hi      = lo_odd_q ? rd_even : rd_odd;
    cur     = {hi, lo};
    shifted = cur >> sh_q;
    value   = shifted[63:0] & mask_q;
    merged  = (cur & ~m128_q) | d128_q;
    we_lo   = (state == S_EXEC) && (func_q == bafs_pkg::FUNC_STORE) && (|m128_q[63:0]);
    we_hi   = (state == S_EXEC) && (func_q == bafs_pkg::FUNC_STORE) && (|m128_q[127:64]);
    if (state == S_CLEAR) begin
      even_we = 1'b1;
      even_wa = clr_idx;
      even_wd = '0;
      odd_we  = 1'b1;
      odd_wa  = clr_idx;
      odd_wd  = '0;
    end else begin
      even_we = lo_odd_q ? we_hi : we_lo;
      even_wa = even_addr_q;
      even_wd = lo_odd_q ? merged[127:64] : merged[63:0];
      odd_we  = lo_odd_q ? we_lo : we_hi;
      odd_wa  = odd_addr_q;
      odd_wd  = lo_odd_q ? merged[63:0] : merged[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_wa] <= even_wd;
    end
    if (odd_we) begin
      odd_mem[odd_wa] <= odd_wd;
    end
    if (pop) begin
      rd_even <= even_mem[even_ra];
      rd_odd  <= odd_mem[odd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      func_q      <= head.req.func;
      status_q    <= head.status;
      sh_q        <= sh;
      mask_q      <= mask;
      m128_q      <= {64'b0, mask} << sh;
      d128_q      <= {64'b0, head.req.store_data & mask} << sh;
      lo_odd_q    <= w[0];
      even_addr_q <= even_ra;
      odd_addr_q  <= odd_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(BANK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done          <= 1'b1;
          rsp.load_data <= (func_q == bafs_pkg::FUNC_LOAD) ? value : '0;
          rsp.status    <= status_q;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bit_addressed_field_store.sv =====
// bit_addressed_field_store: load and store of 0..64 bit fields at any bit address
// the back end reads memory, then writes back, before it takes the next request;
// a taken request is queued, popped with the memory read, then done is registered;
// the receiver cannot stall, a 2-deep queue lets requests wait behind the back end;
// after rst both memory banks are zeroed word by word with busy high
// depends on bafs_pkg, bafs_front, bafs_queue, bafs_back
`default_nettype none

module bit_addressed_field_store #(
  parameter int STORAGE_WORDS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire bafs_pkg::req_t req,
  output logic                done,
  output bafs_pkg::rsp_t      rsp,
  input  wire logic           cfg_write,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [12:0]    cfg_data
);

  bafs_pkg::cfg_t cfg;
  bafs_pkg::cmd_t push_cmd;
  bafs_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  logic           clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.storage_bits  <= bafs_pkg::STORAGE_BITS_RESET;
      cfg.window_enable <= 1'b0;
      cfg.window_base   <= '0;
      cfg.window_bits   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bafs_pkg::CFG_STORAGE_BITS:  cfg.storage_bits  <= cfg_data;
        bafs_pkg::CFG_WINDOW_ENABLE: cfg.window_enable <= cfg_data[0];
        bafs_pkg::CFG_WINDOW_BASE:   cfg.window_base   <= cfg_data;
        bafs_pkg::CFG_WINDOW_BITS:   cfg.window_bits   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bafs_front #(
    .STORAGE_WORDS(STORAGE_WORDS)
  ) u_front (
    .start    (start),
    .req      (req),
    .cfg      (cfg),
    .full     (full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .cmd      (push_cmd)
  );

  bafs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  bafs_back #(
    .STORAGE_WORDS(STORAGE_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
